FILE: hdl/rle_palette_overlay_expander_top_macros.svh
// Assertion helpers for the overlay expander. Define ASSERT_OFF to drop them.
`ifndef RLE_PALETTE_OVERLAY_EXPANDER_TOP_MACROS_SVH
`define RLE_PALETTE_OVERLAY_EXPANDER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define RPOE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cons must hold in the cycle after ante
`define RPOE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RPOE_ASSERT(lbl, clk, rst_n, prop, msg)
`define RPOE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/rpoe_pkg.sv
package rpoe_pkg;

    localparam int FP_W    = 23;   // frame_pixels register
    localparam int OFS_W   = 22;   // start_offset field
    localparam int LEN_W   = 16;   // run_length / pixel_count
    localparam int IDX_W   = 8;
    localparam int CH_W    = 8;
    localparam int ARGB_W  = 32;
    localparam int ACC_W   = 21;   // signed Q10 accumulator

    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_RUN     = 1'b1;

    // BT.601 coefficients, Q10
    localparam logic signed [ACC_W-1:0] K_Y  = ACC_W'(1192);
    localparam logic signed [ACC_W-1:0] K_BB = ACC_W'(2066);
    localparam logic signed [ACC_W-1:0] K_GR = ACC_W'(833);
    localparam logic signed [ACC_W-1:0] K_GB = ACC_W'(400);
    localparam logic signed [ACC_W-1:0] K_RR = ACC_W'(1634);

    localparam logic [CH_W:0] Y_OFS = 9'd16;
    localparam logic [CH_W:0] C_OFS = 9'd128;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [ARGB_W-1:0] argb;
    } t_pal_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_pal_rd;

    // floor, then clamp to 0..255
    function automatic logic [CH_W-1:0] clamp_q10(input logic signed [ACC_W-1:0] acc);
        logic [CH_W-1:0] res;
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (acc[ACC_W-2:18] != '0) begin
            res = '1;
        end else begin
            res = acc[17:10];
        end
        return res;
    endfunction

    // floor(x / 255) for any 16-bit x up to 255*255
    function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

FILE: hdl/rpoe_in_if.sv
interface rpoe_in_if;
    import rpoe_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [IDX_W-1:0]    entry_index;
    logic [CH_W-1:0]     luma;
    logic [CH_W-1:0]     chroma_blue;
    logic [CH_W-1:0]     chroma_red;
    logic [CH_W-1:0]     opacity;
    logic [LEN_W-1:0]    run_length;
    logic [IDX_W-1:0]    color_index;

    modport source (
        output valid, req_type, entry_index, luma, chroma_blue, chroma_red, opacity,
               run_length, color_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, luma, chroma_blue, chroma_red, opacity,
               run_length, color_index,
        output ready
    );
endinterface

FILE: hdl/rpoe_out_if.sv
interface rpoe_out_if;
    import rpoe_pkg::*;

    logic                valid;
    logic                ready;
    logic [ARGB_W-1:0]   pixel_argb;
    logic [OFS_W-1:0]    start_offset;
    logic [LEN_W-1:0]    pixel_count;
    logic                frame_done;

    modport source (
        output valid, pixel_argb, start_offset, pixel_count, frame_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_argb, start_offset, pixel_count, frame_done,
        output ready
    );
endinterface

FILE: hdl/rpoe_cfg_if.sv
interface rpoe_cfg_if;
    import rpoe_pkg::*;

    logic            valid;
    logic            ready;
    logic [FP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/rpoe_convert.sv
module rpoe_convert #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  logic [rpoe_pkg::IDX_W-1:0] i_entry_index,
    input  logic [rpoe_pkg::CH_W-1:0]  i_luma,
    input  logic [rpoe_pkg::CH_W-1:0]  i_chroma_blue,
    input  logic [rpoe_pkg::CH_W-1:0]  i_chroma_red,
    input  logic [rpoe_pkg::CH_W-1:0]  i_opacity,
    output rpoe_pkg::t_pal_wr          o_wr,
    output logic                       o_busy
);
    import rpoe_pkg::*;

    logic r_v1, r_v2, r_v3;

    // stage 1: offset-removed inputs
    logic                    r_en1;
    logic [IDX_W-1:0]        r_idx1;
    logic signed [CH_W:0]    r_y1, r_b1, r_r1;
    logic [CH_W-1:0]         r_t1;

    // stage 2: Q10 accumulators
    logic                    r_en2;
    logic [IDX_W-1:0]        r_idx2;
    logic signed [ACC_W-1:0] r_acc_r2, r_acc_g2, r_acc_b2;
    logic [CH_W-1:0]         r_t2;

    // stage 3: channel times opacity
    logic                    r_en3;
    logic [IDX_W-1:0]        r_idx3;
    logic [15:0]             r_p_r3, r_p_g3, r_p_b3;
    logic [CH_W-1:0]         r_t3;

    logic signed [ACC_W-1:0] n_acc_r, n_acc_g, n_acc_b;
    logic signed [ACC_W-1:0] y_ext, b_ext, r_ext;

    always_comb begin
        y_ext   = ACC_W'(r_y1);
        b_ext   = ACC_W'(r_b1);
        r_ext   = ACC_W'(r_r1);
        n_acc_r = K_Y * y_ext + K_RR * r_ext;
        n_acc_g = K_Y * y_ext - K_GR * r_ext - K_GB * b_ext;
        n_acc_b = K_Y * y_ext + K_BB * b_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_en1  <= int'(i_entry_index) < PALETTE_ENTRIES;
            r_idx1 <= i_entry_index;
            r_y1   <= $signed({1'b0, i_luma} - Y_OFS);
            r_b1   <= $signed({1'b0, i_chroma_blue} - C_OFS);
            r_r1   <= $signed({1'b0, i_chroma_red} - C_OFS);
            r_t1   <= i_opacity;
        end
        r_en2    <= r_en1;
        r_idx2   <= r_idx1;
        r_acc_r2 <= n_acc_r;
        r_acc_g2 <= n_acc_g;
        r_acc_b2 <= n_acc_b;
        r_t2     <= r_t1;

        r_en3  <= r_en2;
        r_idx3 <= r_idx2;
        r_p_r3 <= clamp_q10(r_acc_r2) * r_t2;
        r_p_g3 <= clamp_q10(r_acc_g2) * r_t2;
        r_p_b3 <= clamp_q10(r_acc_b2) * r_t2;
        r_t3   <= r_t2;
    end

    always_comb begin
        o_wr.en   = r_v3 && r_en3;
        o_wr.idx  = r_idx3;
        o_wr.argb = {r_t3, div255(r_p_r3), div255(r_p_g3), div255(r_p_b3)};
        o_busy    = r_v1 || r_v2 || r_v3;
    end

endmodule

FILE: hdl/rpoe_palette.sv
module rpoe_palette #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rpoe_pkg::t_pal_wr           i_wr,
    input  rpoe_pkg::t_pal_rd           i_rd,
    output logic [rpoe_pkg::ARGB_W-1:0] o_rd_argb
);
    import rpoe_pkg::*;

    localparam int IW = $clog2(PALETTE_ENTRIES);

    logic [ARGB_W-1:0]          r_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_valid;
    logic [ARGB_W-1:0]          r_rd_data;
    logic                       r_rd_ok;

    // an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.idx[IW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx[IW-1:0]] <= i_wr.argb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.idx[IW-1:0]];
            r_rd_ok   <= (int'(i_rd.idx) < PALETTE_ENTRIES) && r_valid[i_rd.idx[IW-1:0]];
        end
    end

    assign o_rd_argb = r_rd_ok ? r_rd_data : '0;

endmodule

FILE: hdl/rpoe_run.sv
module rpoe_run #(
    parameter int POSITION_BITS = 22
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rpoe_cfg_if.sink                    i_cfg,
    rpoe_out_if.source                  o_res,
    input  logic                        i_run_acc,
    input  logic [rpoe_pkg::LEN_W-1:0]  i_run_length,
    input  logic [rpoe_pkg::ARGB_W-1:0] i_rd_argb,
    output logic                        o_can_take
);
    import rpoe_pkg::*;

    localparam int TW = (POSITION_BITS + 1 > 24) ? POSITION_BITS + 1 : 24;

    logic [TW-1:0]            r_total;
    logic [POSITION_BITS-1:0] r_pos;

    logic                     r_s1_valid;
    logic [OFS_W-1:0]         r_s1_start;
    logic [LEN_W-1:0]         r_s1_count;
    logic                     r_s1_done;

    logic                     r_o_valid;
    logic [ARGB_W-1:0]        r_o_argb;
    logic [OFS_W-1:0]         r_o_start;
    logic [LEN_W-1:0]         r_o_count;
    logic                     r_o_done;

    logic [TW-1:0]            fp_ext, limit, n_total;
    logic [TW-1:0]            pos_ext, len_ext, remaining;
    logic [OFS_W+POSITION_BITS-1:0] start_ext;
    logic                     full, clip, done;
    logic [LEN_W-1:0]         count;
    logic [POSITION_BITS-1:0] n_pos;
    logic                     s1_move;

    always_comb begin
        fp_ext    = {{(TW - FP_W){1'b0}}, i_cfg.data};
        limit     = TW'(1) << POSITION_BITS;
        n_total   = (fp_ext > limit) ? limit : fp_ext;

        pos_ext   = {{(TW - POSITION_BITS){1'b0}}, r_pos};
        len_ext   = {{(TW - LEN_W){1'b0}}, i_run_length};
        remaining = r_total - pos_ext;
        full      = pos_ext >= r_total;
        clip      = len_ext >= remaining;
        done      = full || clip;
        priority if (full) begin
            count = '0;
        end else if (clip) begin
            count = remaining[LEN_W-1:0];
        end else begin
            count = i_run_length;
        end
        // without a clip the sum stays below the total
        n_pos     = done ? '0 : r_pos + POSITION_BITS'(i_run_length);
        start_ext = {{OFS_W{1'b0}}, r_pos};

        s1_move    = r_s1_valid && (!r_o_valid || o_res.ready);
        o_can_take = !r_s1_valid || s1_move;
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_total <= n_total;
                r_pos   <= '0;
            end else if (i_run_acc) begin
                r_pos <= n_pos;
            end

            if (i_run_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // hold the run until its palette word is back
    always_ff @(posedge i_clk) begin
        if (i_run_acc) begin
            r_s1_start <= start_ext[OFS_W-1:0];
            r_s1_count <= count;
            r_s1_done  <= done;
        end
        if (s1_move) begin
            r_o_argb  <= i_rd_argb;
            r_o_start <= r_s1_start;
            r_o_count <= r_s1_count;
            r_o_done  <= r_s1_done;
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.pixel_argb   = r_o_argb;
    assign o_res.start_offset = r_o_start;
    assign o_res.pixel_count  = r_o_count;
    assign o_res.frame_done   = r_o_done;

endmodule

FILE: hdl/rle_palette_overlay_expander_top.sv
// Run-length palette overlay expander. Palette items convert Y/Cb/Cr/T to a
// premultiplied ARGB word in a three-stage pipeline and write it into a
// 256-word palette memory; the block takes no item while such a conversion
// is in flight. For a run item the palette memory is read on acceptance and
// the word returns in the cycle after; the run descriptor waits in a hold
// register and moves with the word into the output register. A new run is
// taken every cycle while the output drains. The palette resets to zero
// through per-entry valid bits, so there is no clearing pass. Write
// frame_pixels only while the block is idle; the write also returns the
// pixel position to zero.
`include "rle_palette_overlay_expander_top_macros.svh"

module rle_palette_overlay_expander_top #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int POSITION_BITS   = 22
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpoe_cfg_if.sink   i_cfg,
    rpoe_in_if.sink    i_item,
    rpoe_out_if.source o_res
);
    import rpoe_pkg::*;

    t_pal_wr           pal_wr;
    t_pal_rd           pal_rd;
    logic [ARGB_W-1:0] rd_argb;
    logic              pal_busy;
    logic              can_take;
    logic              item_acc;
    logic              pal_acc;
    logic              run_acc;

    always_comb begin
        i_item.ready = !pal_busy && can_take;
        item_acc     = i_item.valid && i_item.ready;
        pal_acc      = item_acc && (i_item.req_type == REQ_PALETTE);
        run_acc      = item_acc && (i_item.req_type == REQ_RUN);
        pal_rd.en    = run_acc;
        pal_rd.idx   = i_item.color_index;
    end

    rpoe_convert #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_convert (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (pal_acc),
        .i_entry_index (i_item.entry_index),
        .i_luma        (i_item.luma),
        .i_chroma_blue (i_item.chroma_blue),
        .i_chroma_red  (i_item.chroma_red),
        .i_opacity     (i_item.opacity),
        .o_wr          (pal_wr),
        .o_busy        (pal_busy)
    );

    rpoe_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (pal_wr),
        .i_rd      (pal_rd),
        .o_rd_argb (rd_argb)
    );

    rpoe_run #(
        .POSITION_BITS (POSITION_BITS)
    ) u_run (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .o_res        (o_res),
        .i_run_acc    (run_acc),
        .i_run_length (i_item.run_length),
        .i_rd_argb    (rd_argb),
        .o_can_take   (can_take)
    );

    `RPOE_ASSERT(a_no_accept_busy, i_clk, i_rst_n, !(pal_busy && item_acc), "item taken during conversion")
    `RPOE_ASSERT_NEXT(a_pal_enters, i_clk, i_rst_n, pal_acc, pal_busy, "palette item lost")
    `RPOE_ASSERT(a_wr_in_flight, i_clk, i_rst_n, !pal_wr.en || pal_busy, "stray palette write")
    `RPOE_ASSERT(a_rd_wr_apart, i_clk, i_rst_n, !(pal_rd.en && pal_wr.en), "read overlaps write")

endmodule
